### src/blcw_pkg.sv
// ----------------------------------------------------------------------------
// blcw_pkg: shared types and constants of the line cell walker
// Holds the coordinate widths, the grid limit, the register codes and the
// segment record that goes from the front end to the walker.
// ----------------------------------------------------------------------------
package blcw_pkg;

    // Largest grid side; coordinates are clamped to GRID_MAX - 1.
    localparam int GRID_MAX = 64;

    localparam int COORD_W = 6;
    localparam int SIZE_W  = 7;
    localparam int INDEX_W = 12;
    // The error term stays within about +/- 1.5 times the largest span.
    localparam int ERR_W   = COORD_W + 3;

    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_MAX - 1);
    localparam logic [SIZE_W-1:0]  SIZE_MAX  = SIZE_W'(GRID_MAX);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] GRID_RESET = SIZE_W'(64);

    // Segment queue between front end and walker.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified segment.
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [COORD_W-1:0] span_x;
        logic [COORD_W-1:0] span_y;
        logic               x_down;
        logic               y_down;
    } t_seg;

    // Clamp a coordinate to the grid limit.
    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        return (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    // Clamp a grid size register to the grid limit.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        return (v > SIZE_MAX) ? SIZE_MAX : v;
    endfunction

endpackage

### src/bresenham_line_cell_walker.sv
// ----------------------------------------------------------------------------
// bresenham_line_cell_walker: Bresenham line rasterizer over a cell grid
// Walks every cell of a segment in any octant and reports each point with
// its row-major index, its coordinates, a clip flag and an end mark.
//
//   Channel   Direction  Handshake                  Payload
//   segment   in         i_in_valid / o_in_ready    start_x, start_y, end_x, end_y
//   point     out        o_out_valid / i_out_ready  cell_index, cell_x, cell_y,
//                                                   inside_res, last_point
//   config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A segment yields max(|dx|, |dy|) + 1 points, one per cycle from the walker
// unless stalled; a segment passes the intake register and the queue first.
// The intake register and a two-entry queue take further segments while one
// is being walked, and the next segment starts in the cycle after the end point.
// Synchronous active-low reset empties the queue and the walker and sets both
// grid sizes to 64. A stalled point holds the walker; the intake fills behind it.
// ----------------------------------------------------------------------------
module bresenham_line_cell_walker
    import blcw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [SIZE_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [COORD_W-1:0]   i_start_x,
    input  logic [COORD_W-1:0]   i_start_y,
    input  logic [COORD_W-1:0]   i_end_x,
    input  logic [COORD_W-1:0]   i_end_y,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [INDEX_W-1:0]   o_cell_index,
    output logic [COORD_W-1:0]   o_cell_x,
    output logic [COORD_W-1:0]   o_cell_y,
    output logic                 o_inside_res,
    output logic                 o_last_point
);

    logic [SIZE_W-1:0] r_grid_width;
    logic [SIZE_W-1:0] r_grid_height;
    logic              front_valid;
    logic              queue_full_n;
    t_seg              front_seg;
    logic              queue_valid;
    logic              queue_pop;
    t_seg              queue_seg;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_RESET;
            r_grid_height <= GRID_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                REG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    blcw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .o_seg_valid (front_valid),
        .i_seg_ready (queue_full_n),
        .o_seg       (front_seg)
    );

    blcw_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (front_valid),
        .i_data   (front_seg),
        .o_full_n (queue_full_n),
        .i_pop    (queue_pop),
        .o_valid  (queue_valid),
        .o_data   (queue_seg)
    );

    blcw_walk u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_width      (clamp_size(r_grid_width)),
        .i_height     (clamp_size(r_grid_height)),
        .i_seg_valid  (queue_valid),
        .i_seg        (queue_seg),
        .o_seg_pop    (queue_pop),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_cell_index (o_cell_index),
        .o_cell_x     (o_cell_x),
        .o_cell_y     (o_cell_y),
        .o_inside_res (o_inside_res),
        .o_last_point (o_last_point)
    );

endmodule

### src/blcw_front.sv
// ----------------------------------------------------------------------------
// blcw_front: segment intake
// Accepts a segment, clamps its endpoints, works out spans and step
// directions, and holds the record until the queue takes it.
// ----------------------------------------------------------------------------
module blcw_front
    import blcw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COORD_W-1:0] i_start_x,
    input  logic [COORD_W-1:0] i_start_y,
    input  logic [COORD_W-1:0] i_end_x,
    input  logic [COORD_W-1:0] i_end_y,
    output logic               o_seg_valid,
    input  logic               i_seg_ready,
    output t_seg               o_seg
);

    logic r_valid;
    t_seg r_seg;
    t_seg n_seg;
    logic [COORD_W-1:0] x0, y0, x1, y1;

    // Classification of the incoming segment.
    always_comb begin
        x0 = clamp_coord(i_start_x);
        y0 = clamp_coord(i_start_y);
        x1 = clamp_coord(i_end_x);
        y1 = clamp_coord(i_end_y);
        n_seg.start_x = x0;
        n_seg.start_y = y0;
        n_seg.end_x   = x1;
        n_seg.end_y   = y1;
        n_seg.span_x  = (x1 > x0) ? (x1 - x0) : (x0 - x1);
        n_seg.span_y  = (y1 > y0) ? (y1 - y0) : (y0 - y1);
        n_seg.x_down  = !(x0 < x1);
        n_seg.y_down  = !(y0 < y1);
    end

    assign o_ready     = !r_valid || i_seg_ready;
    assign o_seg_valid = r_valid;
    assign o_seg       = r_seg;

    // Holding register; takes a transaction when empty or as the old one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_seg <= n_seg;
        end
    end

endmodule

### src/blcw_queue.sv
// ----------------------------------------------------------------------------
// blcw_queue: segment queue
// A short first-in first-out queue of classified segments that decouples
// the intake from the walker.
// ----------------------------------------------------------------------------
module blcw_queue
    import blcw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_seg i_data,
    output logic o_full_n,
    input  logic i_pop,
    output logic o_valid,
    output t_seg o_data
);

    t_seg              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full_n = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_data   = r_mem[r_rd_ptr];
    assign do_push  = i_push && o_full_n;
    assign do_pop   = i_pop && o_valid;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### src/blcw_walk.sv
// ----------------------------------------------------------------------------
// blcw_walk: Bresenham walker
// Steps through the cells of one segment per queue entry, one point per cycle
// unless stalled; drives the result register with index, clip flag, end mark.
// ----------------------------------------------------------------------------
module blcw_walk
    import blcw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [SIZE_W-1:0]  i_width,
    input  logic [SIZE_W-1:0]  i_height,
    input  logic               i_seg_valid,
    input  t_seg               i_seg,
    output logic               o_seg_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [INDEX_W-1:0] o_cell_index,
    output logic [COORD_W-1:0] o_cell_x,
    output logic [COORD_W-1:0] o_cell_y,
    output logic               o_inside_res,
    output logic               o_last_point
);

    // Walk state.
    logic                     r_active;
    logic [COORD_W-1:0]       r_x, r_y, r_tx, r_ty;
    logic signed [ERR_W-1:0]  r_dx, r_dy, r_err;
    logic                     r_x_down, r_y_down;

    // Result register.
    logic                     r_out_valid;
    logic [INDEX_W-1:0]       r_index;
    logic [COORD_W-1:0]       r_ox, r_oy;
    logic                     r_inside, r_last;

    logic                     advance;
    logic                     is_last;
    logic                     in_grid;
    logic [COORD_W+SIZE_W:0]  full_index;
    logic signed [ERR_W:0]    e2;
    logic                     step_x, step_y;
    logic signed [ERR_W-1:0]  n_err;
    logic [COORD_W-1:0]       n_x, n_y;

    assign advance   = r_active && (!r_out_valid || i_ready);
    assign is_last   = (r_x == r_tx) && (r_y == r_ty);
    assign o_seg_pop = i_seg_valid && (!r_active || (advance && is_last));

    // Point classification and row-major index.
    always_comb begin
        in_grid    = ({1'b0, r_x} < i_width) && ({1'b0, r_y} < i_height);
        full_index = (COORD_W+SIZE_W+1)'(r_y) * (COORD_W+SIZE_W+1)'(i_width)
                   + (COORD_W+SIZE_W+1)'(r_x);
    end

    // Next point along the error term.
    always_comb begin
        e2     = {r_err, 1'b0};
        step_x = (e2 >= (ERR_W+1)'(r_dy));
        step_y = (e2 <= (ERR_W+1)'(r_dx));
        n_err  = r_err;
        n_x    = r_x;
        n_y    = r_y;
        if (step_x) begin
            n_err = n_err + r_dy;
            n_x   = r_x_down ? (r_x - 1'b1) : (r_x + 1'b1);
        end
        if (step_y) begin
            n_err = n_err + r_dx;
            n_y   = r_y_down ? (r_y - 1'b1) : (r_y + 1'b1);
        end
    end

    // Walker control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (o_seg_pop) begin
            r_active <= 1'b1;
        end else if (advance && is_last) begin
            r_active <= 1'b0;
        end
    end

    // Walker datapath: load a new segment or step to the next point.
    always_ff @(posedge i_clk) begin
        if (o_seg_pop) begin
            r_x      <= i_seg.start_x;
            r_y      <= i_seg.start_y;
            r_tx     <= i_seg.end_x;
            r_ty     <= i_seg.end_y;
            r_dx     <= ERR_W'(i_seg.span_x);
            r_dy     <= -$signed(ERR_W'(i_seg.span_y));
            r_err    <= $signed(ERR_W'(i_seg.span_x)) - $signed(ERR_W'(i_seg.span_y));
            r_x_down <= i_seg.x_down;
            r_y_down <= i_seg.y_down;
        end else if (advance) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_err <= n_err;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_index  <= in_grid ? full_index[INDEX_W-1:0] : '0;
            r_ox     <= r_x;
            r_oy     <= r_y;
            r_inside <= in_grid;
            r_last   <= is_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_cell_index = r_index;
    assign o_cell_x     = r_ox;
    assign o_cell_y     = r_oy;
    assign o_inside_res = r_inside;
    assign o_last_point = r_last;

endmodule

### bench/blcw_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// blcw_scoreboard_pkg: expected cell points of the line cell walker bench
// Holds a bit-accurate Bresenham walk of each accepted segment against the
// current grid size, and checks every accepted point in order against it.
// ----------------------------------------------------------------------------
package blcw_scoreboard_pkg;
    import blcw_pkg::*;

    // One expected or observed point of a walked segment.
    typedef struct {
        logic [INDEX_W-1:0] cell_index;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic               in_grid;
        logic               last;
    } t_cell_point;

    class cell_walk_board;
        logic [SIZE_W-1:0] grid_width;
        logic [SIZE_W-1:0] grid_height;
        t_cell_point       pending_points[$];
        int                errors;
        int                segments_walked;
        int                points_checked;
        int                points_outside;

        function new();
            grid_width      = GRID_RESET;
            grid_height     = GRID_RESET;
            errors          = 0;
            segments_walked = 0;
            points_checked  = 0;
            points_outside  = 0;
        endfunction

        // Mirror a write of a grid size register.
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
            if (idx == REG_GRID_WIDTH) begin
                grid_width = value;
            end else if (idx == REG_GRID_HEIGHT) begin
                grid_height = value;
            end
        endfunction

        // Walk an accepted segment and queue every point it visits.
        function void add_segment(logic [COORD_W-1:0] x0, logic [COORD_W-1:0] y0,
                                  logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1);
            int          x, y, xe, ye, dx, dy, sx, sy, err, e2, w, h, n;
            t_cell_point p;
            // Sizes beyond the grid limit act as the limit itself.
            w  = (grid_width > GRID_MAX) ? GRID_MAX : grid_width;
            h  = (grid_height > GRID_MAX) ? GRID_MAX : grid_height;
            // Endpoints saturate at the last coordinate of the grid limit.
            x  = (x0 > GRID_MAX - 1) ? GRID_MAX - 1 : x0;
            y  = (y0 > GRID_MAX - 1) ? GRID_MAX - 1 : y0;
            xe = (x1 > GRID_MAX - 1) ? GRID_MAX - 1 : x1;
            ye = (y1 > GRID_MAX - 1) ? GRID_MAX - 1 : y1;
            dx  = (xe > x) ? xe - x : x - xe;
            dy  = (ye > y) ? y - ye : ye - y;
            sx  = (x < xe) ? 1 : -1;
            sy  = (y < ye) ? 1 : -1;
            err = dx + dy;
            segments_walked++;
            for (n = 0; n < GRID_MAX; n++) begin
                p.cell_x     = COORD_W'(x);
                p.cell_y     = COORD_W'(y);
                p.in_grid    = (x < w) && (y < h);
                p.cell_index = p.in_grid ? INDEX_W'(y * w + x) : '0;
                p.last       = (x == xe) && (y == ye);
                pending_points.insert(pending_points.size(), p);
                if (p.last) begin
                    break;
                end
                e2 = 2 * err;
                if (e2 >= dy) begin
                    err += dy;
                    x   += sx;
                end
                if (e2 <= dx) begin
                    err += dx;
                    y   += sy;
                end
            end
        endfunction

        function void compare_field(string name, logic [INDEX_W-1:0] want,
                                    logic [INDEX_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        // Check one accepted point against the oldest expected point.
        function void check_point(logic [INDEX_W-1:0] cell_index,
                                  logic [COORD_W-1:0] cell_x, logic [COORD_W-1:0] cell_y,
                                  logic in_grid, logic last);
            t_cell_point want;
            if (pending_points.size() == 0) begin
                errors++;
                $display("%0t: unexpected point, expected none, actual x=%0d y=%0d",
                         $time, cell_x, cell_y);
                return;
            end
            want = pending_points.pop_front();
            points_checked++;
            if (!want.in_grid) begin
                points_outside++;
            end
            compare_field("cell_index", want.cell_index, cell_index);
            compare_field("cell_x", INDEX_W'(want.cell_x), INDEX_W'(cell_x));
            compare_field("cell_y", INDEX_W'(want.cell_y), INDEX_W'(cell_y));
            compare_field("inside_res", INDEX_W'(want.in_grid), INDEX_W'(in_grid));
            compare_field("last_point", INDEX_W'(want.last), INDEX_W'(last));
        endfunction
    endclass

endpackage

### bench/tb_bresenham_line_cell_walker.sv
// ----------------------------------------------------------------------------
// tb_bresenham_line_cell_walker: self-checking bench of the line cell walker
// Sends directed and random segments under several grid sizes and handshake
// idling patterns, and checks every emitted cell point against its own walk.
// ----------------------------------------------------------------------------
module tb_bresenham_line_cell_walker;
    timeunit 1ns;
    timeprecision 1ps;

    import blcw_pkg::*;
    import blcw_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT     = 400_000;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 9;
    localparam int TAIL_CYCLES     = 16;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [SIZE_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [COORD_W-1:0]   i_start_x;
    logic [COORD_W-1:0]   i_start_y;
    logic [COORD_W-1:0]   i_end_x;
    logic [COORD_W-1:0]   i_end_y;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [INDEX_W-1:0]   o_cell_index;
    logic [COORD_W-1:0]   o_cell_x;
    logic [COORD_W-1:0]   o_cell_y;
    logic                 o_inside_res;
    logic                 o_last_point;

    cell_walk_board board;
    int             sender_idle_pct;
    int             receiver_idle_pct;
    int             cycle_count = 0;
    int             grid_settings = 0;

    bresenham_line_cell_walker DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cell_index (o_cell_index),
        .o_cell_x     (o_cell_x),
        .o_cell_y     (o_cell_y),
        .o_inside_res (o_inside_res),
        .o_last_point (o_last_point)
    );

    always #4 i_clk = ~i_clk;

    // Guard against a hang: the run may not exceed the cycle budget.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The receiver drops ready at random in the current share of cycles.
    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= receiver_idle_pct);
    end

    // Every accepted point transaction is checked in order.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_point(o_cell_index, o_cell_x, o_cell_y, o_inside_res, o_last_point);
        end
    end

    function automatic int fit_coord(int v);
        return (v < 0) ? 0 : (v > GRID_MAX - 1) ? GRID_MAX - 1 : v;
    endfunction

    // Present one segment transaction, idling first at random, and note it once taken.
    task automatic send_segment(input int x0, input int y0, input int x1, input int y1);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_start_x  = COORD_W'(x0);
        i_start_y  = COORD_W'(y0);
        i_end_x    = COORD_W'(x1);
        i_end_y    = COORD_W'(y1);
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        board.add_segment(i_start_x, i_start_y, i_end_x, i_end_y);
    endtask

    // Mostly long random lines, with short, degenerate, axis and diagonal ones mixed in.
    task automatic send_random_segment();
        int x0, y0, x1, y1, kind, len;
        x0   = $urandom_range(GRID_MAX - 1);
        y0   = $urandom_range(GRID_MAX - 1);
        x1   = $urandom_range(GRID_MAX - 1);
        y1   = $urandom_range(GRID_MAX - 1);
        kind = $urandom_range(9);
        if (kind == 5 || kind == 6) begin
            x1 = fit_coord(x0 + int'($urandom_range(12)) - 6);
            y1 = fit_coord(y0 + int'($urandom_range(12)) - 6);
        end else if (kind == 7) begin
            x1 = x0;
            y1 = y0;
        end else if (kind == 8) begin
            if ($urandom_range(1) == 1) begin
                x1 = x0;
            end else begin
                y1 = y0;
            end
        end else if (kind == 9) begin
            len = $urandom_range(30, 1);
            x1  = fit_coord(($urandom_range(1) == 1) ? x0 + len : x0 - len);
            y1  = fit_coord(($urandom_range(1) == 1) ? y0 + len : y0 - len);
        end
        send_segment(x0, y0, x1, y1);
    endtask

    // Hold the segment channel idle until every expected point has arrived.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (board.pending_points.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Write both grid sizes; only called while the walker is idle.
    task automatic write_grid(input logic [SIZE_W-1:0] width, input logic [SIZE_W-1:0] height);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = REG_GRID_WIDTH;
        i_cfg_data = width;
        @(negedge i_clk);
        i_cfg_idx  = REG_GRID_HEIGHT;
        i_cfg_data = height;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        board.set_reg(REG_GRID_WIDTH, width);
        board.set_reg(REG_GRID_HEIGHT, height);
        grid_settings++;
    endtask

    initial begin
        int                phase;
        int                k;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;

        board             = new();
        sender_idle_pct   = 16;
        receiver_idle_pct = 76;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_GRID_WIDTH;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_start_x  = '0;
        i_start_y  = '0;
        i_end_x    = '0;
        i_end_y    = '0;
        i_out_ready = 1'b0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed segments under the reset grid: corners, full diagonals,
        // edges, one line per octant and single-point segments.
        send_segment(0, 0, 0, 0);
        send_segment(63, 63, 63, 63);
        send_segment(0, 0, 63, 63);
        send_segment(63, 63, 0, 0);
        send_segment(0, 63, 63, 0);
        send_segment(63, 0, 0, 63);
        send_segment(0, 0, 63, 0);
        send_segment(63, 0, 0, 0);
        send_segment(0, 0, 0, 63);
        send_segment(0, 63, 0, 0);
        send_segment(10, 10, 20, 13);
        send_segment(10, 10, 13, 20);
        send_segment(10, 10, 0, 13);
        send_segment(10, 10, 7, 20);
        send_segment(10, 10, 20, 7);
        send_segment(10, 10, 13, 0);
        send_segment(10, 10, 0, 7);
        send_segment(10, 10, 7, 0);
        send_segment(5, 9, 5, 9);
        wait_drained();

        // Random phases: the grid changes each phase, the idling pattern every three.
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase < 3) begin
                sender_idle_pct   = 16;
                receiver_idle_pct = 76;
            end else if (phase < 6) begin
                sender_idle_pct   = 76;
                receiver_idle_pct = 16;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            case (phase)
                0: begin width = 7'd0;   height = 7'd0;   end
                1: begin width = 7'd127; height = 7'd127; end
                2: begin width = 7'd1;   height = 7'd1;   end
                3: begin width = 7'd65;  height = 7'd33;  end
                4: begin width = 7'd20;  height = 7'd64;  end
                6: begin width = 7'd64;  height = 7'd0;   end
                8: begin width = 7'd64;  height = 7'd64;  end
                default: begin
                    width  = SIZE_W'($urandom_range(127));
                    height = SIZE_W'($urandom_range(127));
                end
            endcase
            write_grid(width, height);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Once mid-phase, let the walker run dry before sending more.
                if (phase == 4 && k == ITEMS_PER_PHASE / 2) begin
                    wait_drained();
                end
                send_random_segment();
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Walked %0d segments into %0d checked points (%0d outside the grid),",
                 board.segments_walked, board.points_checked, board.points_outside);
        $display("over %0d grid settings and three idling patterns in %0d cycles.",
                 grid_settings + 1, cycle_count);
        if (board.errors == 0 && board.pending_points.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d points never seen",
                     board.errors, board.pending_points.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
